@@ rtl/core/wamt_pkg.sv @@
`timescale 1ns / 1ps
// Weekly alarm match table: shared types, codes and helpers.
// Used by every module under rtl/core; depends on nothing.
package wamt_pkg;

  // Table geometry
  localparam int MAX_ALARMS = 64;
  localparam int IDX_W      = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ALARMS + 1);

  // Operation codes carried on the mode field
  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_DEL = 2'd1,
    MODE_CHK = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  // One stored alarm, 42 bits
  typedef struct packed {
    logic [7:0] id;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] effect;
    logic [7:0] delay;
    logic [6:0] mask;
  } entry_t;

  // Search key held for the length of one operation
  typedef struct packed {
    mode_t      op;
    logic [7:0] id;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] dbit;
  } key_t;

  // One result word
  typedef struct packed {
    logic       fired;
    logic [7:0] effect;
    logic [7:0] delay;
    logic       accepted;
  } res_t;

  // Mask bit for a weekday: Sunday (and the unused code seven) is bit 0,
  // Monday bit 6 down to Saturday bit 1.
  function automatic logic [2:0] day_bit(input logic [2:0] wd);
    logic [2:0] b;
    if (wd == 3'd0 || wd == 3'd7) begin
      b = 3'd0;
    end else begin
      b = 3'd7 - wd;
    end
    return b;
  endfunction

endpackage

@@ rtl/core/wamt_mem.sv @@
`timescale 1ns / 1ps
// Alarm entry storage: one write port, one read port with registered data.
// Depends on wamt_pkg for the entry type and table depth.
module wamt_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [wamt_pkg::IDX_W-1:0] wa,
  input  wamt_pkg::entry_t          wd,
  input  logic [wamt_pkg::IDX_W-1:0] ra,
  output wamt_pkg::entry_t          rd
);

  wamt_pkg::entry_t mem [wamt_pkg::MAX_ALARMS];

  // Write the new or moved entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

@@ rtl/core/wamt_cmp.sv @@
`timescale 1ns / 1ps
// Shared match unit: tests one table entry against the held search key.
// Depends on wamt_pkg for the entry and key types.
module wamt_cmp (
  input  wamt_pkg::entry_t entry,
  input  wamt_pkg::key_t   key,
  output logic             hit
);

  logic id_eq;
  logic time_eq;

  // Compare id for delete, enable bit and time for check
  assign id_eq   = (entry.id == key.id);
  assign time_eq = entry.mask[key.dbit] && (entry.hour == key.hour) &&
                   (entry.minute == key.minute);

  always_comb begin
    case (key.op)
      wamt_pkg::MODE_DEL: hit = id_eq;
      wamt_pkg::MODE_CHK: hit = time_eq;
      default:            hit = 1'b0;
    endcase
  end

endmodule

@@ rtl/core/weekly_alarm_match_table.sv @@
`timescale 1ns / 1ps
// Weekly alarm match table top level: sequencer, output register.
// Depends on wamt_pkg, wamt_mem and wamt_cmp.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   mode, id, time, effect, delay, mask, day
//  out_     output     out_valid / out_stall fired, effect, delay, accepted
//
// Add writes the new entry when it is accepted, unless the table is full. Check and delete
// walk the table one entry per cycle through the single read port and the shared match
// unit: a check stops at the first hit or the end of the table, and a delete walks to
// the hit, moves each later entry down one place and then closes the gap.
// in_stall is high from acceptance until the result is loaded into the
// output register; a held output only delays that load.
// Reset empties the table by clearing the entry count; storage is not swept.
module weekly_alarm_match_table (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_alarm_id,
  input  logic [4:0] in_hour,
  input  logic [5:0] in_minute,
  input  logic [7:0] in_effect,
  input  logic [7:0] in_effect_delay,
  input  logic [6:0] in_day_mask,
  input  logic [2:0] in_weekday,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_fired,
  output logic [7:0] out_fire_effect,
  output logic [7:0] out_fire_delay,
  output logic       out_accepted
);

  localparam int CW = wamt_pkg::CNT_W;
  localparam int IW = wamt_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    idx_inc, idx_dec;
  wamt_pkg::key_t   key_r, key_nxt;
  wamt_pkg::res_t   res_r, res_nxt;
  wamt_pkg::res_t   out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  logic [IW-1:0]    mem_ra;
  wamt_pkg::entry_t mem_wd;
  wamt_pkg::entry_t mem_rd;
  wamt_pkg::entry_t new_entry;
  logic             hit;
  logic             in_take;
  logic             out_free;

  wamt_mem u_mem (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  wamt_cmp u_cmp (
    .entry (mem_rd),
    .key   (key_r),
    .hit   (hit)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);

  assign new_entry.id     = in_alarm_id;
  assign new_entry.hour   = in_hour;
  assign new_entry.minute = in_minute;
  assign new_entry.effect = in_effect;
  assign new_entry.delay  = in_effect_delay;
  assign new_entry.mask   = in_day_mask;

  // Sequence one operation over the table
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_wa    = count_r[IW-1:0];
    mem_wd    = new_entry;
    mem_ra    = idx_inc[IW-1:0];
    case (state_r)
      ST_IDLE: begin
        mem_ra = '0;
        if (in_take) begin
          key_nxt.op     = wamt_pkg::mode_t'(in_mode);
          key_nxt.id     = in_alarm_id;
          key_nxt.hour   = in_hour;
          key_nxt.minute = in_minute;
          key_nxt.dbit   = wamt_pkg::day_bit(in_weekday);
          res_nxt        = '0;
          idx_nxt        = '0;
          state_nxt      = ST_FIN;
          case (wamt_pkg::mode_t'(in_mode))
            wamt_pkg::MODE_ADD: begin
              // Append unless full
              if (count_r < CW'(wamt_pkg::MAX_ALARMS)) begin
                mem_we           = 1'b1;
                count_nxt        = count_r + CW'(1);
                res_nxt.accepted = 1'b1;
              end
            end
            wamt_pkg::MODE_DEL, wamt_pkg::MODE_CHK: begin
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Test the entry at idx_r, read the next one
        if (hit) begin
          if (key_r.op == wamt_pkg::MODE_DEL) begin
            idx_nxt   = idx_inc;
            state_nxt = ST_SHIFT;
          end else begin
            res_nxt.fired  = 1'b1;
            res_nxt.effect = mem_rd.effect;
            res_nxt.delay  = mem_rd.delay;
            state_nxt      = ST_FIN;
          end
        end else if (idx_inc == count_r) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_SHIFT: begin
        // Move the entry at idx_r down one place, close the gap at the end
        if (idx_r == count_r) begin
          count_nxt        = count_r - CW'(1);
          res_nxt.accepted = 1'b1;
          state_nxt        = ST_FIN;
        end else begin
          mem_we  = 1'b1;
          mem_wa  = idx_dec[IW-1:0];
          mem_wd  = mem_rd;
          idx_nxt = idx_inc;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Load the output word, drop it once taken
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_FIN && out_free) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload and working registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_fired       = out_r.fired;
  assign out_fire_effect = out_r.effect;
  assign out_fire_delay  = out_r.delay;
  assign out_accepted    = out_r.accepted;

  // The entry count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(wamt_pkg::MAX_ALARMS))
    else $error("alarm count beyond table depth");

  // The count moves by at most one per operation
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)))
    else $error("alarm count jumped");

  // A shift write lands inside the valid part of the table
  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) && mem_we |-> (idx_r != '0) && (idx_r < count_r))
    else $error("shift write outside table");

  // A new output word only comes from the finish state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("output loaded outside finish");

endmodule
